[hw/rtl/hfc_pkg.sv]
// Package for the hex float converter: mode codes, payload types, helpers.
// No dependencies.
package hfc_pkg;

   typedef enum logic [1:0] {
      MODE_S2S = 2'd0,
      MODE_S2D = 2'd1,
      MODE_L2D = 2'd2,
      MODE_RSV = 2'd3
   } mode_type;

   typedef struct packed {
      logic [63:0] hex_word;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [63:0] ieee_word;
      logic        overflowed;
      logic        last_out;
   } rsp_type;

   // Classified item passed from front to back.
   typedef struct packed {
      logic        sgn;
      logic        zero;
      logic        is_long;
      logic        to_single;
      logic [6:0]  ex;
      logic [55:0] sig;   // normalized, leading one at bit 55
      logic [5:0]  lz;
      logic        last;
   } work_type;

   localparam int unsigned QDepth = 2;

   // Leading zero count over 56 bits (v nonzero).
   function automatic logic [5:0] lzc56(input logic [55:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd0;
      found = 1'b0;
      for (int i = 55; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 6'(55 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

[hw/rtl/hfc_stream_if.sv]
// Valid/ready stream interfaces, each carrying one payload type.
// Depends on hfc_pkg.
interface hfc_req_if;
   import hfc_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hfc_rsp_if;
   import hfc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/hfc_front.sv]
// Front stage: extract fields, count leading zeros, normalize; registered output.
// Depends on hfc_pkg and hfc_req_if.
module hfc_front (
   input  logic               clock,
   input  logic               reset,
   input  hfc_pkg::mode_type  mode,
   hfc_req_if.sink            req,
   output logic               out_valid,
   output hfc_pkg::work_type  out_data,
   input  logic               out_ready
);
   import hfc_pkg::*;

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;
   logic [55:0] man;
   logic [5:0]  lz;

   assign req.ready = !valid_ff || out_ready;

   always_comb begin
      data_in.is_long   = mode[1];
      data_in.to_single = (mode == MODE_S2S);
      if (mode[1]) begin
         man = req.payload.hex_word[55:0];
         data_in.sgn = req.payload.hex_word[63];
         data_in.ex  = req.payload.hex_word[62:56];
      end else begin
         man = {req.payload.hex_word[23:0], 32'd0};
         data_in.sgn = req.payload.hex_word[31];
         data_in.ex  = req.payload.hex_word[30:24];
      end
      lz            = lzc56(man);
      data_in.lz    = lz;
      data_in.zero  = (man == 56'd0);
      data_in.sig   = man << lz;
      data_in.last  = req.payload.last_in;
      valid_in      = req.valid ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req.ready && req.valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

[hw/rtl/hfc_queue.sv]
// Two-entry queue between front and back halves.
// Depends on hfc_pkg.
module hfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hfc_pkg::work_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output hfc_pkg::work_type out_data,
   input  logic              out_ready
);
   import hfc_pkg::*;

   work_type mem_ff [QDepth];
   logic     wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic     push, pop;

   assign in_ready  = (count_ff != 2'(QDepth));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

[hw/rtl/hfc_back.sv]
// Back stage: rebias exponent, round long fractions, pack IEEE result.
// Depends on hfc_pkg and hfc_rsp_if.
module hfc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hfc_pkg::work_type in_data,
   output logic              in_ready,
   hfc_rsp_if.source         rsp
);
   import hfc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic signed [10:0] e;
   logic [2:0]  low;
   logic [53:0] kept;
   logic [11:0] bexp;

   assign in_ready = !valid_ff || rsp.ready;

   always_comb begin
      // binary exponent: (digits*4-1 - lz) + 4*(ex-64-digits) = 4*ex-257-lz
      e    = $signed({2'b00, in_data.ex, 2'b00}) - 11'sd257
             - $signed({5'd0, in_data.lz});
      low  = in_data.sig[2:0];
      kept = {1'b0, in_data.sig[55:3]};
      bexp = 12'd0;
      data_in.ieee_word  = 64'd0;
      data_in.overflowed = 1'b0;
      data_in.last_out   = in_data.last;
      if (in_data.to_single) begin
         data_in.ieee_word[31] = in_data.sgn;
         if (!in_data.zero) begin
            if (e > 11'sd127) begin
               data_in.ieee_word[30:23] = 8'hff;
               data_in.overflowed = 1'b1;
            end else if (e >= -11'sd126) begin
               data_in.ieee_word[30:23] = 8'(e + 11'sd127);
               data_in.ieee_word[22:0]  = in_data.sig[54:32];
            end
         end
      end else begin
         data_in.ieee_word[63] = in_data.sgn;
         if (!in_data.zero) begin
            if (in_data.is_long) begin
               if (low > 3'd4 || (low == 3'd4 && kept[0])) kept = kept + 54'd1;
               bexp = 12'(e + 11'sd1023);
               if (kept[53]) begin
                  kept = kept >> 1;
                  bexp = bexp + 12'd1;
               end
               data_in.ieee_word[51:0] = kept[51:0];
            end else begin
               bexp = 12'(e + 11'sd1023);
               data_in.ieee_word[51:29] = in_data.sig[54:32];
            end
            data_in.ieee_word[62:52] = bexp[10:0];
         end
      end
      valid_in = in_valid ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp.valid   = valid_ff;
   assign rsp.payload = data_ff;
endmodule

[hw/rtl/hex_float_to_ieee_converter.sv]
// Hexadecimal float to IEEE 754 converter, top level.
// A transfer passes the front register, the two-entry queue and the back register in order.
// Throughput: one transfer per cycle while the response side does not stall;
// the front normalizer and back packer are decoupled by a two-entry queue.
// Reset: synchronous, active high; clears all valid state and sets
// the mode register mode_ff to short-to-single.
module hex_float_to_ieee_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   hfc_req_if.sink     req,
   hfc_rsp_if.source   rsp
);
   import hfc_pkg::*;

   mode_type mode_ff;
   logic     f_valid, f_ready, q_valid, q_ready;
   work_type f_data, q_data;

   // Hold the mode register; the user must write it only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_S2S;
      end else if (csr_write_enable) begin
         mode_ff <= mode_type'(csr_write_data);
      end
   end

   // Front: classify and normalize each transfer.
   hfc_front u_front (
      .clock, .reset, .mode(mode_ff), .req,
      .out_valid(f_valid), .out_data(f_data), .out_ready(f_ready)
   );

   // Queue: let front and back stall independently.
   hfc_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_data(f_data), .in_ready(f_ready),
      .out_valid(q_valid), .out_data(q_data), .out_ready(q_ready)
   );

   // Back: rebias, round and pack.
   hfc_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_data(q_data), .in_ready(q_ready), .rsp
   );
endmodule

[tb/sv/hex_float_to_ieee_converter_checker.sv]
// Checker for the hex float converter: watches both streams, predicts each
// IEEE result from the accepted source word and the current format mode.
// Depends on hfc_pkg and the stream interfaces.
`timescale 1ns / 100ps
module hex_float_to_ieee_converter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   hfc_req_if          req,
   hfc_rsp_if          rsp,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   import hfc_pkg::*;

   rsp_type   ieee_queue[$];
   mode_type  cur_mode;

   // Count leading zeros of a nonzero value inside a field of given width.
   function automatic int count_lead(input logic [63:0] v, input int width);
      int n;
      n = 0;
      while (n < width && !v[width - 1 - n]) n++;
      return n;
   endfunction

   function automatic rsp_type convert_word(input logic [63:0] w, input logic last,
                                            input mode_type m);
      rsp_type r;
      logic [63:0] frac, sig, kept;
      logic [2:0]  low;
      int lz, ex, e;
      r = '0;
      r.last_out = last;
      if (!m[1]) begin
         frac = {40'd0, w[23:0]};
         ex = int'(w[30:24]);
         if (m == MODE_S2S) begin
            r.ieee_word[31] = w[31];
            if (frac != 0) begin
               lz = count_lead(frac, 24);
               sig = (frac << lz) & 64'hffffff;
               e = (23 - lz) + 4 * (ex - 64 - 6);
               if (e > 127) begin
                  r.ieee_word[30:23] = 8'hff;
                  r.overflowed = 1'b1;
               end else if (e >= -126) begin
                  r.ieee_word[30:23] = 8'(e + 127);
                  r.ieee_word[22:0] = sig[22:0];
               end
            end
         end else begin
            r.ieee_word[63] = w[31];
            if (frac != 0) begin
               lz = count_lead(frac, 24);
               sig = (frac << lz) & 64'hffffff;
               e = (23 - lz) + 4 * (ex - 64 - 6);
               r.ieee_word[62:52] = 11'(e + 1023);
               r.ieee_word[51:29] = sig[22:0];
            end
         end
      end else begin
         frac = {8'd0, w[55:0]};
         ex = int'(w[62:56]);
         r.ieee_word[63] = w[63];
         if (frac != 0) begin
            lz = count_lead(frac, 56);
            sig = (frac << lz) & 64'h00ff_ffff_ffff_ffff;
            e = (55 - lz) + 4 * (ex - 64 - 14);
            low = sig[2:0];
            kept = sig >> 3;
            if (low > 3'd4 || (low == 3'd4 && kept[0])) kept = kept + 1;
            if (kept[53]) begin
               kept = kept >> 1;
               e = e + 1;
            end
            r.ieee_word[62:52] = 11'(e + 1023);
            r.ieee_word[51:0] = kept[51:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cur_mode <= MODE_S2S;
         ieee_queue.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_write_enable) cur_mode <= mode_type'(csr_write_data);
         if (req.valid && req.ready)
            ieee_queue.push_back(convert_word(req.payload.hex_word,
                                              req.payload.last_in, cur_mode));
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (ieee_queue.size() == 0) begin
               $error("result with nothing expected: ieee_word %h", rsp.payload.ieee_word);
               fail_count++;
            end else begin
               want = ieee_queue.pop_front();
               if (rsp.payload.ieee_word !== want.ieee_word) begin
                  $error("ieee_word expected %h actual %h", want.ieee_word,
                         rsp.payload.ieee_word);
                  fail_count++;
               end
               if (rsp.payload.overflowed !== want.overflowed) begin
                  $error("overflowed expected %b actual %b", want.overflowed,
                         rsp.payload.overflowed);
                  fail_count++;
               end
               if (rsp.payload.last_out !== want.last_out) begin
                  $error("last_out expected %b actual %b", want.last_out,
                         rsp.payload.last_out);
                  fail_count++;
               end
            end
         end
      end
      pending_count = ieee_queue.size();
   end
endmodule

[tb/sv/hex_float_to_ieee_converter_tb.sv]
// Top of the hex float converter testbench: clock, reset, stimulus, verdict.
// Depends on hfc_pkg, the stream interfaces and the checker module.
`timescale 1ns / 100ps
module hex_float_to_ieee_converter_tb;
   import hfc_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;
   int         fail_count, pending_count, result_count;
   int         word_count;
   bit         calm_phase;     // no idling on either side
   bit         hold_off_req;   // ask the sink to stall a long stretch

   hfc_req_if req ();
   hfc_rsp_if rsp ();

   hex_float_to_ieee_converter uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .rsp              (rsp)
   );

   hex_float_to_ieee_converter_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .rsp              (rsp),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .result_count     (result_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Sink side: drop ready at random about 10% of the time; on request hold
   // it low for a long stretch so the queue fills and the input stalls.
   initial begin
      int stall_left;
      rsp.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req && stall_left == 0) stall_left = 60;
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= calm_phase || ($urandom_range(99) >= 10);
         end
      end
   end

   // Offer one word; idle at random first, then hold valid until transfer.
   // Ready comes from registers only, so its value at the falling edge is
   // the value seen at the next rising edge.
   task automatic send_word(input logic [63:0] w, input logic last);
      while (!calm_phase && $urandom_range(99) < 10) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= '{hex_word: w, last_in: last};
      while (!req.ready) @(negedge clock);
      word_count++;
      @(negedge clock);
   endtask

   // Drain everything, then allow the pipeline latency before a mode change.
   task automatic set_mode(input mode_type m);
      req.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Build a random word biased toward interesting exponents and fractions.
   function automatic logic [63:0] random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(7))
         0: w[55:0] = 56'd0;                            // zero fraction
         1: w[55:0] = 56'd1 << $urandom_range(55);      // single set bit
         2: w[23:0] = 24'd1 << $urandom_range(23);
         3: w[2:0] = 3'b100;                            // tie in long rounding
         4: w[55:0] = {56{1'b1}} >> $urandom_range(3);  // carry on round up
         default: ;
      endcase
      if ($urandom_range(3) == 0) w[30:24] = $urandom_range(1) ? 7'h7f : 7'h00;
      if ($urandom_range(3) == 0) w[62:56] = $urandom_range(1) ? 7'h7f : 7'h00;
      return w;
   endfunction

   initial begin
      mode_type modes[4];
      logic [63:0] directed[$];
      modes = '{MODE_S2S, MODE_S2D, MODE_L2D, MODE_RSV};
      word_count = 0;
      calm_phase = 1'b0;
      hold_off_req = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = MODE_S2S;
      req.valid = 1'b0;
      req.payload = '0;
      reset = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Extremes: zeros with any exponent, largest and smallest exponents,
      // overflow and flush bounds in single, long rounding ties and carries.
      directed = '{64'h0, 64'hffff_ffff_8000_0000, 64'h0000_0000_7fff_ffff,
                   64'h0000_0000_0000_0001, 64'h0000_0000_ffff_ffff,
                   64'h0000_0000_6100_0001, 64'h0000_0000_6080_0000,
                   64'h0000_0000_2110_0000, 64'h0000_0000_2100_0001,
                   64'h0000_0000_4110_0000, 64'hffff_ffff_c1ff_ffff,
                   64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                   64'h0000_0000_0000_0004, 64'h0000_0000_0000_000c,
                   64'h0000_0000_0000_0014, 64'h40ff_ffff_ffff_fffc,
                   64'hc100_0000_0000_0001, 64'h4011_1111_1111_1118,
                   64'h7f80_0000_0000_0000};
      // Mode 0 is the reset value; run the directed set once per mode.
      for (int m = 0; m < 4; m++) begin
         if (m != 0) set_mode(modes[m]);
         foreach (directed[i]) send_word(directed[i], i[0]);
      end

      // Random phases in randomly picked modes, each with a calm stretch and one
      // long sink hold-off while the source keeps offering words.
      for (int phase = 0; phase < 8; phase++) begin
         set_mode(modes[$urandom_range(3)]);
         for (int i = 0; i < 220; i++) begin
            calm_phase = (i >= 100 && i < 160);
            hold_off_req = (i == 40);
            send_word(random_word(), $urandom_range(1));
         end
         calm_phase = 1'b0;
         hold_off_req = 1'b0;
      end
      // Make sure mode 0 and mode 2 both see random traffic at the end.
      set_mode(MODE_S2S);
      for (int i = 0; i < 50; i++) send_word(random_word(), $urandom_range(1));
      set_mode(MODE_L2D);
      for (int i = 0; i < 50; i++) send_word(random_word(), $urandom_range(1));

      req.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Converted %0d words, %0d results checked, in all four format modes,",
               word_count, result_count);
      $display("with zero, overflow, flush and long rounding cases and stalls on both sides.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
